// ===== rtl/sssd_pkg.sv =====
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, constants and the glyph table of the seven-segment scan driver.
// ----------------------------------------------------------------------------
`default_nettype none

package sssd_pkg;

   localparam int unsigned GLYPH_COUNT = 25;
   localparam int unsigned POSITIONS   = 5;

   localparam logic [4:0] BLANK_CODE = 5'd23;
   localparam logic [13:0] FREQ_MAX  = 14'd9999;
   localparam logic [13:0] FREQ_MIN  = 14'd1;
   localparam logic [7:0]  DUTY_MAX  = 8'd100;
   localparam logic [7:0]  DUTY_MIN  = 8'd1;

   localparam logic [2:0] PHASE_INIT  = 3'd0;
   localparam logic [2:0] PHASE_FIRST = 3'd1;
   localparam logic [2:0] PHASE_LAST  = 3'(POSITIONS);

   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_NUMERIC = 2'd1,
      REQ_RAW     = 2'd2,
      REQ_NOP     = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      CSR_OFF_TICKS   = 4'd0,
      CSR_ON_TICKS    = 4'd1,
      CSR_SHOW_DUTY   = 4'd2,
      CSR_DEGREE_MARK = 4'd3
   } csr_index_type;

   // one request after formatting, as held in the input register
   typedef struct packed {
      req_kind_type     kind;
      logic [3:0][4:0]  codes;
      logic             decimal;
      logic             clamped;
   } item_type;

   typedef struct packed {
      logic [7:0] off_ticks;
      logic [7:0] on_ticks;
      logic       degree_mark;
   } scan_cfg_type;

   localparam logic [31:0][7:0] GLYPHS = {
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h58,
      8'h00, 8'hF3, 8'h40, 8'hBF, 8'h6E, 8'h5E, 8'h79, 8'h54,
      8'h3F, 8'h31, 8'h76, 8'h71, 8'h39, 8'h3F, 8'h6F, 8'h7F,
      8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
   };

   function automatic logic [7:0] glyph_of(input logic [4:0] code);
      logic [7:0] seg;
      seg = 8'h00;
      if ({1'b0, code} < 6'(GLYPH_COUNT)) begin
         seg = GLYPHS[code];
      end
      return seg;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sssd_format.sv =====
// ----------------------------------------------------------------------------
// sssd_format
// Clamps a numeric load and splits it into four digit codes with leading-zero
// blanking; passes raw codes through.
// ----------------------------------------------------------------------------
`default_nettype none

module sssd_format
   import sssd_pkg::*;
(
   input  var req_kind_type kind,
   input  var logic [13:0]  freq_tenths,
   input  var logic [7:0]   duty_percent,
   input  var logic [3:0][4:0] raw_codes,
   input  var logic         show_duty,
   output item_type         item
);

   logic [13:0] freq_sat;
   logic        freq_clamp;
   logic [7:0]  duty_sat;
   logic        duty_clamp;

   logic [27:0] f_prod1000;
   logic [27:0] f_prod100;
   logic [29:0] f_prod10;
   logic [3:0]  q1000;
   logic [6:0]  q100;
   logic [9:0]  q10;
   logic [3:0]  f_d3;
   logic [3:0]  f_d2;
   logic [3:0]  f_d1;
   logic [3:0]  f_d0;
   logic [6:0]  q100_sub;
   logic [9:0]  q10_sub;
   logic [13:0] t_sub;

   logic [15:0] d_prod10;
   logic [3:0]  dq10;
   logic        d_hundred;
   logic [7:0]  d_sub;
   logic [3:0]  d_units;

   logic [3:0][4:0] num_codes;

   always_comb begin
      freq_sat   = freq_tenths;
      freq_clamp = 1'b0;
      if (freq_tenths > FREQ_MAX) begin
         freq_sat   = FREQ_MAX;
         freq_clamp = 1'b1;
      end else if (freq_tenths < FREQ_MIN) begin
         freq_sat   = FREQ_MIN;
         freq_clamp = 1'b1;
      end

      duty_sat   = duty_percent;
      duty_clamp = 1'b0;
      if (duty_percent > DUTY_MAX) begin
         duty_sat   = DUTY_MAX;
         duty_clamp = 1'b1;
      end else if (duty_percent < DUTY_MIN) begin
         duty_sat   = DUTY_MIN;
         duty_clamp = 1'b1;
      end
   end

   // reciprocal multiplies, exact for values up to 9999
   always_comb begin
      f_prod1000 = 28'(freq_sat) * 28'd8389;
      f_prod100  = 28'(freq_sat) * 28'd5243;
      f_prod10   = 30'(freq_sat) * 30'd52429;
      q1000      = f_prod1000[26:23];
      q100       = f_prod100[25:19];
      q10        = f_prod10[28:19];

      q100_sub = q100 - 7'(q1000) * 7'd10;
      q10_sub  = q10 - 10'(q100) * 10'd10;
      t_sub    = freq_sat - 14'(q10) * 14'd10;
      f_d3     = q1000;
      f_d2     = q100_sub[3:0];
      f_d1     = q10_sub[3:0];
      f_d0     = t_sub[3:0];
   end

   always_comb begin
      d_prod10  = 16'(duty_sat) * 16'd205;
      dq10      = d_prod10[14:11];
      d_hundred = (duty_sat == DUTY_MAX);
      d_sub     = duty_sat - 8'(dq10) * 8'd10;
      d_units   = d_sub[3:0];
   end

   always_comb begin
      if (show_duty) begin
         num_codes[0] = BLANK_CODE;
         num_codes[1] = d_hundred ? 5'd1 : BLANK_CODE;
         if (d_hundred) begin
            num_codes[2] = 5'd0;
         end else if (dq10 == 4'd0) begin
            num_codes[2] = BLANK_CODE;
         end else begin
            num_codes[2] = {1'b0, dq10};
         end
         num_codes[3] = {1'b0, d_units};
      end else begin
         num_codes[0] = (f_d3 == 4'd0) ? BLANK_CODE : {1'b0, f_d3};
         num_codes[1] = (f_d2 == 4'd0 && f_d3 == 4'd0) ? BLANK_CODE : {1'b0, f_d2};
         num_codes[2] = {1'b0, f_d1};
         num_codes[3] = {1'b0, f_d0};
      end
   end

   always_comb begin
      item.kind = kind;
      case (kind)
         REQ_NUMERIC: begin
            item.codes   = num_codes;
            item.decimal = ~show_duty;
            item.clamped = show_duty ? duty_clamp : freq_clamp;
         end
         default: begin
            item.codes   = raw_codes;
            item.decimal = 1'b0;
            item.clamped = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/sssd_scan.sv =====
// ----------------------------------------------------------------------------
// sssd_scan
// Scan sequencer, digit store and segment/enable latches; the latches and the
// clamp flag form the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sssd_scan
   import sssd_pkg::*;
(
   input  var logic         clock,
   input  var logic         reset,
   input  var scan_cfg_type cfg,
   input  var logic         item_valid,
   input  var item_type     item,
   output logic             item_take,
   output logic             rsp_valid,
   input  var logic         rsp_ready,
   output logic [7:0]       rsp_segments,
   output logic [POSITIONS-1:0] rsp_enable,
   output logic             rsp_clamped
);

   logic [2:0]           phase_ff, phase_in;
   logic [7:0]           elapsed_ff, elapsed_in;
   logic [7:0]           seg_ff, seg_in;
   logic [POSITIONS-1:0] en_ff, en_in;
   logic [3:0][4:0]      codes_ff, codes_in;
   logic                 dec_ff, dec_in;
   logic                 valid_ff, valid_in;
   logic                 clamped_ff, clamped_in;

   logic [7:0]           elapsed_inc;
   logic [7:0]           pos_seg;
   logic                 phase_ok;

   assign item_take = item_valid && (!valid_ff || rsp_ready);

   always_comb begin
      case (phase_ff)
         3'd1:    pos_seg = glyph_of(codes_ff[0]) & 8'h7F;
         3'd2:    pos_seg = glyph_of(codes_ff[1]);
         3'd3:    pos_seg = {5'b0, cfg.degree_mark, 2'b0};
         3'd4:    pos_seg = glyph_of(codes_ff[2]) | {dec_ff, 7'b0};
         default: pos_seg = glyph_of(codes_ff[3]);
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      seg_in      = seg_ff;
      en_in       = en_ff;
      codes_in    = codes_ff;
      dec_in      = dec_ff;
      clamped_in  = clamped_ff;
      valid_in    = valid_ff && !rsp_ready;
      phase_ok    = (phase_ff >= PHASE_FIRST) && (phase_ff <= PHASE_LAST);
      elapsed_inc = (elapsed_ff == 8'hFF) ? 8'hFF : elapsed_ff + 8'd1;

      if (item_take) begin
         valid_in   = 1'b1;
         clamped_in = (item.kind == REQ_NUMERIC) && item.clamped;
         case (item.kind)
            REQ_TICK: begin
               if (!phase_ok) begin
                  // init phase and unused codes restart the scan
                  seg_in     = 8'h00;
                  en_in      = '0;
                  elapsed_in = 8'h00;
                  phase_in   = PHASE_FIRST;
               end else begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= cfg.off_ticks) begin
                     seg_in = pos_seg;
                     en_in  = POSITIONS'(1) << (phase_ff - PHASE_FIRST);
                  end
                  if (elapsed_inc >= cfg.on_ticks) begin
                     en_in      = '0;
                     elapsed_in = 8'h00;
                     phase_in   = (phase_ff == PHASE_LAST) ? PHASE_FIRST : phase_ff + 3'd1;
                  end
               end
            end
            REQ_NUMERIC, REQ_RAW: begin
               codes_in = item.codes;
               dec_in   = item.decimal;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_INIT;
         elapsed_ff <= 8'h00;
         seg_ff     <= 8'h00;
         en_ff      <= '0;
         codes_ff   <= '0;
         dec_ff     <= 1'b1;
         valid_ff   <= 1'b0;
         clamped_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         seg_ff     <= seg_in;
         en_ff      <= en_in;
         codes_ff   <= codes_in;
         dec_ff     <= dec_in;
         valid_ff   <= valid_in;
         clamped_ff <= clamped_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_segments = seg_ff;
   assign rsp_enable   = en_ff;
   assign rsp_clamped  = clamped_ff;

endmodule

`default_nettype wire

// ===== rtl/seven_segment_scan_driver_unit.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit
// Five-position multiplexed seven-segment driver with numeric formatting.
// ----------------------------------------------------------------------------
// Every request (tick, numeric load, raw load or no-op) yields exactly one
// response carrying the latched segment and enable lines after the update and
// the clamp flag of a numeric load. One request is taken per clock cycle while
// the response side does not stall. A request is first held in the input
// register (numeric values are clamped and split into digits on the way in),
// then the scan/latch register takes it and updates the latches; the response
// comes from the scan/latch register. While a response waits, the input
// register takes one more request only if it is empty, and then holds it.
// Configuration writes are always ready and should be issued while no request
// is in flight.
`default_nettype none

module seven_segment_scan_driver_unit
   import sssd_pkg::*;
(
   input  var logic        clock,
   input  var logic        reset,
   // tdata: freq_tenths[13:0], duty_percent[21:14], code_first[26:22],
   //        code_second[31:27], code_third[36:32], code_fourth[41:37], zero pad
   input  var logic [47:0] req_tdata,
   // tuser: req_type[1:0]
   input  var logic [1:0]  req_tuser,
   input  var logic        req_tvalid,
   output logic            req_tready,
   // tdata: segments[7:0], digit_enable[12:8], clamped[13], zero pad
   output logic [15:0]     rsp_tdata,
   output logic            rsp_tvalid,
   input  var logic        rsp_tready,
   input  var logic        csr_valid,
   output logic            csr_ready,
   input  var logic [3:0]  csr_index,
   input  var logic [7:0]  csr_data
);

   logic [7:0] off_ticks_ff;
   logic [7:0] on_ticks_ff;
   logic       show_duty_ff;
   logic       degree_mark_ff;

   item_type     fmt_item;
   item_type     item_ff, item_in;
   logic         item_valid_ff, item_valid_in;
   logic         item_take;
   scan_cfg_type scan_cfg;
   logic [3:0][4:0] raw_codes;

   logic [7:0]           rsp_segments;
   logic [POSITIONS-1:0] rsp_enable;
   logic                 rsp_clamped;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ticks_ff   <= 8'd1;
         on_ticks_ff    <= 8'd8;
         show_duty_ff   <= 1'b0;
         degree_mark_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OFF_TICKS:   off_ticks_ff   <= csr_data;
            CSR_ON_TICKS:    on_ticks_ff    <= csr_data;
            CSR_SHOW_DUTY:   show_duty_ff   <= csr_data[0];
            CSR_DEGREE_MARK: degree_mark_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign raw_codes[0] = req_tdata[26:22];
   assign raw_codes[1] = req_tdata[31:27];
   assign raw_codes[2] = req_tdata[36:32];
   assign raw_codes[3] = req_tdata[41:37];

   sssd_format u_format (
      .kind         (req_kind_type'(req_tuser)),
      .freq_tenths  (req_tdata[13:0]),
      .duty_percent (req_tdata[21:14]),
      .raw_codes    (raw_codes),
      .show_duty    (show_duty_ff),
      .item         (fmt_item)
   );

   // input register refills whenever it is empty or drains this cycle
   assign req_tready = !item_valid_ff || item_take;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !item_take;
      if (req_tvalid && req_tready) begin
         item_in       = fmt_item;
         item_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign scan_cfg.off_ticks   = off_ticks_ff;
   assign scan_cfg.on_ticks    = on_ticks_ff;
   assign scan_cfg.degree_mark = degree_mark_ff;

   sssd_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .cfg          (scan_cfg),
      .item_valid   (item_valid_ff),
      .item         (item_ff),
      .item_take    (item_take),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_segments (rsp_segments),
      .rsp_enable   (rsp_enable),
      .rsp_clamped  (rsp_clamped)
   );

   assign rsp_tdata = {2'b00, rsp_clamped, rsp_enable, rsp_segments};

   // at most one position is ever enabled
   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(rsp_tdata[12:8]))
      else $error("digit enable not one-hot");

   // a held request is not dropped while the result side stalls
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !item_take |=> item_valid_ff)
      else $error("pending request lost");

   // empty input register always accepts
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> req_tready)
      else $error("input stalled while empty");

   // clamp only reported for numeric loads
   a_clamp_numeric: assert property (@(posedge clock) disable iff (reset)
      item_take && item_ff.kind != REQ_NUMERIC |=> !rsp_tdata[13])
      else $error("clamp flag on non-numeric request");

endmodule

`default_nettype wire
